// File: hdl/tiered_event_ring_store_assert.svh
// Assertion macros for the tiered event ring store checker.
// Expects signals clk and arst_n in the scope of use.
`ifndef TIERED_EVENT_RING_STORE_ASSERT_SVH
`define TIERED_EVENT_RING_STORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define TERS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tiered_event_ring_store assertion failed");

// Next-cycle implication, disabled during reset
`define TERS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tiered_event_ring_store assertion failed");

`endif

// File: hdl/ters_pkg.sv
// Shared types and constants of the tiered event ring store.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ters_pkg;

	// parameter defaults
	localparam int RECORD_SLOTS_DEF = 1024;
	localparam int SUBSYSTEMS_DEF   = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	// configuration
	localparam int          TOTAL_W     = 11;
	localparam logic [10:0] RESET_TOTAL = 11'd1024;
	localparam logic        CFG_TOTAL   = 1'b0;
	localparam logic        CFG_CATALOG = 1'b1;

	// header layout: message, level, presented, subsystem
	localparam int HDR_W = 25;

	// ring numbers
	localparam logic [1:0] RING_PRESENTED = 2'd0;
	localparam logic [1:0] RING_RECORD    = 2'd1;
	localparam logic [1:0] RING_DETAIL    = 2'd2;
	localparam logic [1:0] RING_BOOT      = 2'd3;

	// counter selectors
	localparam logic [4:0] CSEL_DROPPED   = 5'd0;
	localparam logic [4:0] CSEL_LOST      = 5'd1;
	localparam logic [4:0] CSEL_UNATTR    = 5'd2;
	localparam logic [4:0] CSEL_STORED    = 5'd3;
	localparam logic [4:0] CSEL_FILL      = 5'd4;
	localparam logic [4:0] CSEL_EVICT     = 5'd8;
	localparam logic [4:0] CSEL_SUBSYS    = 5'd12;

	typedef enum logic [1:0] {
		OP_APPEND       = 2'd0,
		OP_LOST         = 2'd1,
		OP_READ_ENTRY   = 2'd2,
		OP_READ_COUNTER = 2'd3
	} ters_op_e;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic drop_inc;
		logic victim_rd;
		logic tier_wr;
		logic boot_wr;
		logic lost_add;
		logic entry_rd;
		logic entry_load;
		logic count_load;
	} ters_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic debug_level;
		logic out_free;
	} ters_stat_t;

endpackage

`default_nettype wire

// File: hdl/ters_ctrl.sv
// Sequencing controller of the tiered event ring store.
// Depends on ters_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ters_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic [1:0]          operation,
	input  wire ters_pkg::ters_stat_t stat,
	output ters_pkg::ters_cmd_t      cmd,
	output logic                     busy
);
	import ters_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE    = 8'b0000_0001,
		S_APP_RD  = 8'b0000_0010,
		S_APP_WR  = 8'b0000_0100,
		S_BOOT    = 8'b0000_1000,
		S_LOST    = 8'b0001_0000,
		S_ENT_RD  = 8'b0010_0000,
		S_ENT_OUT = 8'b0100_0000,
		S_CNT     = 8'b1000_0000
	} state_t;

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (ters_op_e'(operation))
						OP_APPEND:     state_nx = S_APP_RD;
						OP_LOST:       state_nx = S_LOST;
						OP_READ_ENTRY: state_nx = S_ENT_RD;
						default:       state_nx = S_CNT;
					endcase
				end
			end
			S_APP_RD: begin
				if (stat.debug_level) begin
					cmd.drop_inc = 1'b1;
					state_nx     = S_IDLE;
				end else begin
					cmd.victim_rd = 1'b1;
					state_nx      = S_APP_WR;
				end
			end
			S_APP_WR: begin
				cmd.tier_wr = 1'b1;
				state_nx    = S_BOOT;
			end
			S_BOOT: begin
				cmd.boot_wr = 1'b1;
				state_nx    = S_IDLE;
			end
			S_LOST: begin
				cmd.lost_add = 1'b1;
				state_nx     = S_IDLE;
			end
			S_ENT_RD: begin
				cmd.entry_rd = 1'b1;
				state_nx     = S_ENT_OUT;
			end
			S_ENT_OUT: begin
				if (stat.out_free) begin
					cmd.entry_load = 1'b1;
					state_nx       = S_IDLE;
				end
			end
			S_CNT: begin
				if (stat.out_free) begin
					cmd.count_load = 1'b1;
					state_nx       = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

`default_nettype wire

// File: hdl/ters_datapath.sv
// Datapath of the tiered event ring store: record memory, ring pointers,
// counters, partition registers and the result register. Depends on ters_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ters_datapath #(
	parameter int RECORD_SLOTS = ters_pkg::RECORD_SLOTS_DEF,
	parameter int SUBSYSTEMS   = ters_pkg::SUBSYSTEMS_DEF,
	parameter int PAYLOAD_BITS = ters_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ters_pkg::ters_cmd_t  cmd,
	output ters_pkg::ters_stat_t      stat,
	// configuration
	input  wire logic                 cfg_we,
	input  wire logic                 cfg_index,
	input  wire logic [10:0]          cfg_data,
	// input item
	input  wire logic [2:0]           level,
	input  wire logic                 presented,
	input  wire logic [15:0]          message_id,
	input  wire logic [4:0]           origin_subsystem,
	input  wire logic [63:0]          stamp,
	input  wire logic [31:0]          payload,
	input  wire logic [31:0]          lost_records,
	input  wire logic [1:0]           ring_select,
	input  wire logic [9:0]           age_index,
	input  wire logic [4:0]           counter_select,
	// result
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic                      reply_kind,
	output logic                      found,
	output logic [15:0]               out_message,
	output logic [2:0]                out_level,
	output logic                      out_presented,
	output logic [4:0]                out_subsystem,
	output logic [63:0]               out_stamp,
	output logic [31:0]               out_payload,
	output logic [31:0]               counter_value
);
	import ters_pkg::*;

	localparam int AW = $clog2(RECORD_SLOTS);
	localparam int CW = AW + 1;
	localparam int TW = (CW > TOTAL_W) ? CW : TOTAL_W;
	localparam int OW = ((CW > 10) ? CW : 10) + 1;
	localparam int SW = (SUBSYSTEMS > 1) ? $clog2(SUBSYSTEMS) : 1;
	localparam int EW = HDR_W + 64 + PAYLOAD_BITS;

	typedef struct packed {
		logic [3:0][CW-1:0] cap;
		logic [3:0][AW-1:0] base;
	} geom_t;

	// ring sizes from the configured slot count
	function automatic geom_t calc_geom(input logic [TOTAL_W-1:0] total);
		logic [TW-1:0] tot_w;
		logic [CW-1:0] cnt, p, r, b;
		logic [CW+1:0] t3;
		geom_t         g;
		tot_w = TW'(total);
		if (tot_w > TW'(RECORD_SLOTS)) cnt = CW'(RECORD_SLOTS);
		else                           cnt = CW'(tot_w);
		p  = cnt >> 3;
		t3 = {2'b00, cnt} + {1'b0, cnt, 1'b0};
		r  = CW'(t3 >> 3);
		b  = cnt - p - r - r;
		if (p == '0 || r == '0 || b == '0) begin
			p = '0;
			r = '0;
			b = '0;
		end
		g.cap[RING_PRESENTED]  = p;
		g.cap[RING_RECORD]     = r;
		g.cap[RING_DETAIL]     = r;
		g.cap[RING_BOOT]       = b;
		g.base[RING_PRESENTED] = '0;
		g.base[RING_RECORD]    = AW'(p);
		g.base[RING_DETAIL]    = AW'(p + r);
		g.base[RING_BOOT]      = AW'(p + r + r);
		return g;
	endfunction

	// one compare and subtract: sum is below twice the capacity
	function automatic logic [AW-1:0] ring_off(input logic [OW-1:0] sum,
	                                           input logic [CW-1:0] cap);
		logic [OW-1:0] cap_w;
		cap_w = OW'(cap);
		if (sum >= cap_w) return AW'(sum - cap_w);
		return AW'(sum);
	endfunction

	// configuration and partition
	geom_t         geom_q;
	logic          catalog_q;

	// latched item
	logic [2:0]              level_q;
	logic                    pres_q;
	logic [15:0]             msg_q;
	logic [4:0]              sub_q;
	logic [63:0]             stamp_q;
	logic [PAYLOAD_BITS-1:0] payload_q;
	logic [31:0]             lost_q;
	logic [1:0]              ring_q;
	logic [9:0]              age_q;
	logic [4:0]              csel_q;

	// ring state and counters
	logic [3:0][CW-1:0]      fill_q;
	logic [3:0][AW-1:0]      head_q;
	logic [3:0][31:0]        ring_evict_q;
	logic [31:0]             sub_evict_q [SUBSYSTEMS];
	logic [31:0]             dropped_q, lost_cnt_q, unattr_q, stored_q;

	// record memory
	logic [EW-1:0]           mem_q [RECORD_SLOTS];
	logic [EW-1:0]           rdata_q;
	logic                    found_q;

	// result register
	logic                    out_valid_q;

	// tier choice for an append
	logic [1:0]    tier;
	logic [CW-1:0] tier_cap, tier_fill, boot_cap, boot_fill;
	logic [AW-1:0] tier_head;
	logic          tier_full, tier_we, boot_we;
	logic [AW-1:0] victim_slot, tier_slot, boot_slot, read_slot;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          mem_we, mem_re;
	logic [EW-1:0] wr_entry;
	logic          entry_found;
	logic [4:0]    ev_sub;
	logic          ev_known;
	logic [4:0]    sub_sel;
	logic [31:0]   count_mux;
	logic [32:0]   lost_sum;

	always_comb begin
		if (pres_q)              tier = RING_PRESENTED;
		else if (level_q <= 3'd1) tier = RING_DETAIL;
		else                     tier = RING_RECORD;
	end

	assign tier_cap    = geom_q.cap[tier];
	assign tier_fill   = fill_q[tier];
	assign tier_head   = head_q[tier];
	assign tier_full   = (tier_fill >= tier_cap);
	assign tier_we     = cmd.tier_wr && (tier_cap != '0);
	assign boot_cap    = geom_q.cap[RING_BOOT];
	assign boot_fill   = fill_q[RING_BOOT];
	assign boot_we     = cmd.boot_wr && (boot_fill < boot_cap);

	// slot addresses
	assign victim_slot = geom_q.base[tier] + tier_head;
	assign tier_slot   = geom_q.base[tier]
	                   + ring_off(OW'(tier_head) + OW'(tier_fill), tier_cap);
	assign boot_slot   = geom_q.base[RING_BOOT]
	                   + ring_off(OW'(head_q[RING_BOOT]) + OW'(boot_fill), boot_cap);
	assign read_slot   = geom_q.base[ring_q]
	                   + ring_off(OW'(head_q[ring_q]) + OW'(age_q), geom_q.cap[ring_q]);
	assign entry_found = (OW'(age_q) < OW'(fill_q[ring_q])) && (geom_q.cap[ring_q] != '0);

	assign wr_addr  = cmd.tier_wr ? tier_slot : boot_slot;
	assign mem_we   = tier_we || boot_we;
	assign rd_addr  = cmd.victim_rd ? victim_slot : read_slot;
	assign mem_re   = cmd.victim_rd || cmd.entry_rd;
	assign wr_entry = {payload_q, stamp_q, sub_q, pres_q, level_q, msg_q};

	// evicted entry attribution
	assign ev_sub   = rdata_q[24:20];
	assign ev_known = catalog_q && ({2'b00, ev_sub} < 7'(SUBSYSTEMS));

	assign lost_sum = {1'b0, lost_cnt_q} + {1'b0, lost_q};

	// counter selection
	always_comb begin
		sub_sel   = csel_q - CSEL_SUBSYS;
		count_mux = '0;
		if (csel_q == CSEL_DROPPED)      count_mux = dropped_q;
		else if (csel_q == CSEL_LOST)    count_mux = lost_cnt_q;
		else if (csel_q == CSEL_UNATTR)  count_mux = unattr_q;
		else if (csel_q == CSEL_STORED)  count_mux = stored_q;
		else if (csel_q < CSEL_EVICT)    count_mux = 32'(fill_q[csel_q[1:0]]);
		else if (csel_q < CSEL_SUBSYS)   count_mux = ring_evict_q[csel_q[1:0]];
		else if ({2'b00, sub_sel} < 7'(SUBSYSTEMS))
			count_mux = sub_evict_q[sub_sel[SW-1:0]];
	end

	// item latch
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			level_q   <= level;
			pres_q    <= presented;
			msg_q     <= message_id;
			sub_q     <= origin_subsystem;
			stamp_q   <= stamp;
			payload_q <= PAYLOAD_BITS'(payload);
			lost_q    <= lost_records;
			ring_q    <= ring_select;
			age_q     <= age_index;
			csel_q    <= counter_select;
		end
	end

	// record memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[wr_addr] <= wr_entry;
		end
		if (mem_re) begin
			rdata_q <= mem_q[rd_addr];
		end
		if (cmd.entry_rd) begin
			found_q <= entry_found;
		end
	end

	// ring pointers, counters and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q       <= calc_geom(RESET_TOTAL);
			catalog_q    <= 1'b1;
			fill_q       <= '0;
			head_q       <= '0;
			ring_evict_q <= '0;
			for (int i = 0; i < SUBSYSTEMS; i++) sub_evict_q[i] <= '0;
			dropped_q    <= '0;
			lost_cnt_q   <= '0;
			unattr_q     <= '0;
			stored_q     <= '0;
		end else begin
			if (cmd.drop_inc) dropped_q <= dropped_q + 32'd1;
			if (cmd.lost_add) begin
				lost_cnt_q <= lost_sum[32] ? '1 : lost_sum[31:0];
			end
			if (cmd.tier_wr) begin
				stored_q <= stored_q + 32'd1;
				if (tier_cap != '0) begin
					if (tier_full) begin
						head_q[tier]       <= ring_off(OW'(tier_head) + OW'(1), tier_cap);
						ring_evict_q[tier] <= ring_evict_q[tier] + 32'd1;
						if (ev_known)
							sub_evict_q[ev_sub[SW-1:0]] <= sub_evict_q[ev_sub[SW-1:0]] + 32'd1;
						else
							unattr_q <= unattr_q + 32'd1;
					end else begin
						fill_q[tier] <= tier_fill + CW'(1);
					end
				end
			end
			if (boot_we) fill_q[RING_BOOT] <= boot_fill + CW'(1);
			// register writes; a new size clears every ring and counter
			if (cfg_we && cfg_index == CFG_CATALOG) catalog_q <= cfg_data[0];
			if (cfg_we && cfg_index == CFG_TOTAL) begin
				geom_q       <= calc_geom(cfg_data);
				fill_q       <= '0;
				head_q       <= '0;
				ring_evict_q <= '0;
				for (int i = 0; i < SUBSYSTEMS; i++) sub_evict_q[i] <= '0;
				dropped_q    <= '0;
				lost_cnt_q   <= '0;
				unattr_q     <= '0;
				stored_q     <= '0;
			end
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.entry_load || cmd.count_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.entry_load) begin
			reply_kind    <= 1'b0;
			found         <= found_q;
			out_message   <= found_q ? rdata_q[15:0]  : '0;
			out_level     <= found_q ? rdata_q[18:16] : '0;
			out_presented <= found_q && rdata_q[19];
			out_subsystem <= found_q ? rdata_q[24:20] : '0;
			out_stamp     <= found_q ? rdata_q[HDR_W +: 64] : '0;
			out_payload   <= found_q ? 32'(rdata_q[HDR_W+64 +: PAYLOAD_BITS]) : '0;
			counter_value <= '0;
		end else if (cmd.count_load) begin
			reply_kind    <= 1'b1;
			found         <= 1'b0;
			out_message   <= '0;
			out_level     <= '0;
			out_presented <= 1'b0;
			out_subsystem <= '0;
			out_stamp     <= '0;
			out_payload   <= '0;
			counter_value <= count_mux;
		end
	end

	assign out_valid        = out_valid_q;
	assign stat.out_free    = !out_valid_q || !out_stall;
	assign stat.debug_level = (level_q == 3'd0);

endmodule

`default_nettype wire

// File: hdl/tiered_event_ring_store.sv
// Tiered event ring store: record memory split into four rings with counters.
// Usage:
//   Input channel (in_valid / in_stall) takes one operation per transaction:
//   append, add lost records, read entry, read counter. Output channel
//   (out_valid / out_stall) returns one reply for each read, none otherwise.
//   Steps of each transaction, set by the record memory's single write port and
//   its registered read (the victim is read before its slot is rewritten):
//     append: accept, victim read, ring write, boot-ring write; debug
//     append: accept, drop count; add lost: accept, add; counter read:
//     accept, counter into the result register; entry read: accept, memory
//     read, registered data into the result register.
//   in_stall stays high until the current transaction is finished.
//   A finished reply waits in the result register while out_stall is high;
//   the next transaction is still taken, and only a second reply waits.
//   Reset clears all rings and counters and restores 1024 slots with the
//   catalog present. Writing total_records repartitions and clears the same
//   way; write registers only while the block is idle.
// Depends on ters_pkg, ters_ctrl, ters_datapath.
`timescale 1ns / 1ps
`default_nettype none

module tiered_event_ring_store #(
	parameter int RECORD_SLOTS = ters_pkg::RECORD_SLOTS_DEF,
	parameter int SUBSYSTEMS   = ters_pkg::SUBSYSTEMS_DEF,
	parameter int PAYLOAD_BITS = ters_pkg::PAYLOAD_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [10:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  operation,
	input  wire logic [2:0]  level,
	input  wire logic        presented,
	input  wire logic [15:0] message_id,
	input  wire logic [4:0]  origin_subsystem,
	input  wire logic [63:0] stamp,
	input  wire logic [31:0] payload,
	input  wire logic [31:0] lost_records,
	input  wire logic [1:0]  ring_select,
	input  wire logic [9:0]  age_index,
	input  wire logic [4:0]  counter_select,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             reply_kind,
	output logic             found,
	output logic [15:0]      out_message,
	output logic [2:0]       out_level,
	output logic             out_presented,
	output logic [4:0]       out_subsystem,
	output logic [63:0]      out_stamp,
	output logic [31:0]      out_payload,
	output logic [31:0]      counter_value
);
	import ters_pkg::*;

	ters_cmd_t  cmd;
	ters_stat_t stat;
	logic       busy;

	ters_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.stat      (stat),
		.cmd       (cmd),
		.busy      (busy)
	);

	ters_datapath #(
		.RECORD_SLOTS (RECORD_SLOTS),
		.SUBSYSTEMS   (SUBSYSTEMS),
		.PAYLOAD_BITS (PAYLOAD_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.level            (level),
		.presented        (presented),
		.message_id       (message_id),
		.origin_subsystem (origin_subsystem),
		.stamp            (stamp),
		.payload          (payload),
		.lost_records     (lost_records),
		.ring_select      (ring_select),
		.age_index        (age_index),
		.counter_select   (counter_select),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.reply_kind       (reply_kind),
		.found            (found),
		.out_message      (out_message),
		.out_level        (out_level),
		.out_presented    (out_presented),
		.out_subsystem    (out_subsystem),
		.out_stamp        (out_stamp),
		.out_payload      (out_payload),
		.counter_value    (counter_value)
	);

	assign in_stall = busy;

endmodule

`default_nettype wire

// File: hdl/ters_checker.sv
// Port-level checker of the tiered event ring store, bound to the top level.
// Depends on tiered_event_ring_store_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "tiered_event_ring_store_assert.svh"

module ters_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        reply_kind,
	input wire logic        found,
	input wire logic [15:0] out_message,
	input wire logic [63:0] out_stamp,
	input wire logic [31:0] out_payload,
	input wire logic [31:0] counter_value
);

	// an accepted transaction makes the input side busy
	`TERS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a stalled reply stays
	`TERS_ASSERT_NEXT(a_reply_held, out_valid && out_stall, out_valid)

	// an entry that was not found carries zero fields
	`TERS_ASSERT_NOW(a_missing_zero, out_valid && !found,
		out_message == 16'd0 && out_stamp == 64'd0 && out_payload == 32'd0)

	// counter replies never report an entry; entry replies carry no count
	`TERS_ASSERT_NOW(a_kind_fields, out_valid,
		reply_kind ? !found : (counter_value == 32'd0))

endmodule

bind tiered_event_ring_store ters_checker u_ters_checker (.*);

`default_nettype wire
